@@ rtl/core/bdeq_pkg.sv @@
`timescale 1ns / 1ps

package bdeq_pkg;

  localparam int NUM_PINS_DEFAULT    = 8;
  localparam int QUEUE_DEPTH_DEFAULT = 16;
  localparam int CMD_DEPTH           = 2;
  localparam int PIN_FIELD_W         = 3;
  localparam int CODE_COUNT          = 256;

  localparam logic [31:0] DEFAULT_DEBOUNCE = 32'd8000;
  localparam logic [31:0] DROP_MAX         = 32'hFFFF_FFFF;

  localparam logic [1:0] OP_EDGE  = 2'd0;
  localparam logic [1:0] OP_POLL  = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_EDGE  = 2'd1;
  localparam logic [1:0] KIND_POLL  = 2'd2;
  localparam logic [1:0] KIND_QUERY = 2'd3;

  localparam logic [1:0] LVL_UNKNOWN  = 2'd0;
  localparam logic [1:0] LVL_PRESSED  = 2'd1;
  localparam logic [1:0] LVL_RELEASED = 2'd2;

  localparam logic TYPE_PRESS   = 1'b0;
  localparam logic TYPE_RELEASE = 1'b1;

  localparam logic CFG_DEBOUNCE = 1'b0;
  localparam logic CFG_PIN_MAP  = 1'b1;

  typedef struct packed {
    logic [1:0]             kind;
    logic [1:0]             lvl;
    logic [PIN_FIELD_W-1:0] pin;
    logic [31:0]            time_us;
    logic [31:0]            time_ms;
    logic [7:0]             query_code;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  code;
    logic        etype;
    logic [31:0] time_ms;
  } evt_t;

endpackage

@@ rtl/core/bdeq_front.sv @@
`timescale 1ns / 1ps

module bdeq_front #(
  parameter int NUM_PINS = bdeq_pkg::NUM_PINS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 clearing,
  output logic                 busy,
  input  logic [1:0]           op,
  input  logic [4:0]           pin,
  input  logic                 edge_fall,
  input  logic                 edge_rise,
  input  logic [31:0]          time_us,
  input  logic [31:0]          time_ms,
  input  logic [7:0]           query_code,
  output logic                 head_valid,
  output bdeq_pkg::cmd_t       head,
  input  logic                 pop
);
  import bdeq_pkg::*;

  localparam int CNT_W = $clog2(CMD_DEPTH + 1);
  localparam int PTR_W = $clog2(CMD_DEPTH);
  localparam logic [4:0] PIN_LIMIT = 5'(NUM_PINS);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CMD_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(CMD_DEPTH - 1);

  cmd_t             fifo [CMD_DEPTH];
  logic [CNT_W-1:0] count;
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  cmd_t             cmd_in;
  logic             push;

  always_comb begin
    cmd_in.lvl        = edge_fall ? LVL_PRESSED : LVL_RELEASED;
    cmd_in.pin        = pin[PIN_FIELD_W-1:0];
    cmd_in.time_us    = time_us;
    cmd_in.time_ms    = time_ms;
    cmd_in.query_code = query_code;
    case (op)
      OP_EDGE: begin
        if ((pin < PIN_LIMIT) && (edge_fall || edge_rise)) begin
          cmd_in.kind = KIND_EDGE;
        end else begin
          cmd_in.kind = KIND_NONE;
        end
      end
      OP_POLL:  cmd_in.kind = KIND_POLL;
      OP_QUERY: cmd_in.kind = KIND_QUERY;
      default:  cmd_in.kind = KIND_NONE;
    endcase
  end

  assign busy       = (count == CNT_FULL) || clearing;
  assign push       = start && !busy;
  assign head_valid = (count != '0);
  assign head       = fifo[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/bdeq_back.sv @@
`timescale 1ns / 1ps

module bdeq_back #(
  parameter int NUM_PINS    = bdeq_pkg::NUM_PINS_DEFAULT,
  parameter int QUEUE_DEPTH = bdeq_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 head_valid,
  input  bdeq_pkg::cmd_t       head,
  output logic                 pop,
  output logic                 clearing,
  input  logic                 cfg_valid,
  input  logic                 cfg_index,
  input  logic [63:0]          cfg_data,
  output logic                 done,
  output logic                 event_valid,
  output logic [7:0]           event_code,
  output logic                 event_type,
  output logic [31:0]          event_time_ms,
  output logic [1:0]           level,
  output logic [31:0]          lost_events
);
  import bdeq_pkg::*;

  localparam int PTR_W  = $clog2(2 * QUEUE_DEPTH);
  localparam int FILL_W = PTR_W + 1;
  localparam int IDX_W  = $clog2(QUEUE_DEPTH);
  localparam int CADR_W = $clog2(CODE_COUNT);
  localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(2 * QUEUE_DEPTH - 1);
  localparam logic [PTR_W-1:0]  DEPTH_P  = PTR_W'(QUEUE_DEPTH);
  localparam logic [FILL_W-1:0] SPAN_F   = FILL_W'(2 * QUEUE_DEPTH);
  localparam logic [FILL_W-1:0] DEPTH_F  = FILL_W'(QUEUE_DEPTH);
  localparam logic [CADR_W-1:0] CADR_LAST = CADR_W'(CODE_COUNT - 1);

  logic [31:0]       deb_limit;
  logic [63:0]       pin_code_map;
  logic [1:0]        pin_level [NUM_PINS];
  logic [31:0]       pin_time  [NUM_PINS];
  evt_t              evq_mem   [QUEUE_DEPTH];
  logic [1:0]        lvl_mem   [CODE_COUNT];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [31:0]       drop_count;
  logic [CADR_W-1:0] clr_addr;

  logic [31:0]       sel_time;
  logic [1:0]        sel_lvl;
  logic [7:0]        code;
  logic [31:0]       deb;
  logic [31:0]       elapsed;
  logic              is_edge;
  logic              is_poll;
  logic              is_query;
  logic              pass;
  logic              change;
  logic [FILL_W-1:0] fill;
  logic              full;
  logic              enq;
  logic              drop;
  logic              deq;
  logic [PTR_W-1:0]  wr_ptr_next;
  logic [PTR_W-1:0]  rd_ptr_next;
  logic [IDX_W-1:0]  wr_idx;
  logic [IDX_W-1:0]  rd_idx;
  evt_t              new_evt;
  logic              lvl_we;
  logic [CADR_W-1:0] lvl_wa;
  logic [1:0]        lvl_wd;

  logic              res_valid;
  logic              res_from_mem;
  logic              res_query;
  evt_t              res_evt;
  evt_t              evq_rd;
  logic [1:0]        lvl_rd;
  evt_t              out_evt;

  assign pop      = head_valid && !clearing;
  assign is_edge  = pop && (head.kind == KIND_EDGE);
  assign is_poll  = pop && (head.kind == KIND_POLL);
  assign is_query = pop && (head.kind == KIND_QUERY);

  always_comb begin
    sel_time = '0;
    sel_lvl  = LVL_UNKNOWN;
    for (int i = 0; i < NUM_PINS; i++) begin
      if (head.pin == PIN_FIELD_W'(i)) begin
        sel_time = pin_time[i];
        sel_lvl  = pin_level[i];
      end
    end
  end

  assign code    = pin_code_map[8 * head.pin +: 8];
  assign deb     = (deb_limit == '0) ? DEFAULT_DEBOUNCE : deb_limit;
  assign elapsed = head.time_us - sel_time;
  assign pass    = is_edge && (code != '0) && (elapsed >= deb);
  assign change  = pass && (sel_lvl != head.lvl);

  assign fill = (wr_ptr >= rd_ptr) ? ({1'b0, wr_ptr} - {1'b0, rd_ptr})
                                   : ({1'b0, wr_ptr} + SPAN_F - {1'b0, rd_ptr});
  assign full = (fill >= DEPTH_F);
  assign enq  = change && !full;
  assign drop = change && full;
  assign deq  = is_poll && (fill != '0);

  assign wr_ptr_next = (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
  assign rd_ptr_next = (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
  assign wr_idx = IDX_W'((wr_ptr >= DEPTH_P) ? wr_ptr - DEPTH_P : wr_ptr);
  assign rd_idx = IDX_W'((rd_ptr >= DEPTH_P) ? rd_ptr - DEPTH_P : rd_ptr);

  assign new_evt.code    = code;
  assign new_evt.etype   = (head.lvl == LVL_RELEASED) ? TYPE_RELEASE : TYPE_PRESS;
  assign new_evt.time_ms = head.time_ms;

  assign lvl_we = clearing || change;
  assign lvl_wa = clearing ? clr_addr : code;
  assign lvl_wd = clearing ? LVL_UNKNOWN : head.lvl;

  always_ff @(posedge clk) begin
    if (enq) begin
      evq_mem[wr_idx] <= new_evt;
    end
    if (deq) begin
      evq_rd <= evq_mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (lvl_we) begin
      lvl_mem[lvl_wa] <= lvl_wd;
    end
    if (is_query) begin
      lvl_rd <= lvl_mem[head.query_code];
    end
  end

  always_ff @(posedge clk) begin
    res_evt <= new_evt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      deb_limit    <= DEFAULT_DEBOUNCE;
      pin_code_map <= '0;
      wr_ptr       <= '0;
      rd_ptr       <= '0;
      drop_count   <= '0;
      clearing     <= 1'b1;
      clr_addr     <= '0;
      done         <= 1'b0;
      res_valid    <= 1'b0;
      res_from_mem <= 1'b0;
      res_query    <= 1'b0;
      for (int i = 0; i < NUM_PINS; i++) begin
        pin_level[i] <= LVL_UNKNOWN;
        pin_time[i]  <= '0;
      end
    end else begin
      if (cfg_valid) begin
        if (cfg_index == CFG_DEBOUNCE) begin
          deb_limit <= cfg_data[31:0];
        end else begin
          pin_code_map <= cfg_data;
        end
      end
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == CADR_LAST) begin
          clearing <= 1'b0;
        end
      end
      for (int i = 0; i < NUM_PINS; i++) begin
        if (pass && (head.pin == PIN_FIELD_W'(i))) begin
          pin_time[i] <= head.time_us;
          pin_level[i] <= head.lvl;
        end
      end
      if (enq) begin
        wr_ptr <= wr_ptr_next;
      end
      if (deq) begin
        rd_ptr <= rd_ptr_next;
      end
      if (drop && (drop_count != DROP_MAX)) begin
        drop_count <= drop_count + 1'b1;
      end
      done         <= pop;
      res_valid    <= enq || deq;
      res_from_mem <= deq;
      res_query    <= is_query;
    end
  end

  assign out_evt       = res_from_mem ? evq_rd : res_evt;
  assign event_valid   = res_valid;
  assign event_code    = res_valid ? out_evt.code : 8'd0;
  assign event_type    = res_valid ? out_evt.etype : 1'b0;
  assign event_time_ms = res_valid ? out_evt.time_ms : 32'd0;
  assign level         = res_query ? lvl_rd : LVL_UNKNOWN;
  assign lost_events   = drop_count;

endmodule

@@ rtl/core/button_debounce_event_queue.sv @@
`timescale 1ns / 1ps

// Channel  | Handshake                   | Payload
// ---------+-----------------------------+----------------------------------------------
// command  | start in, busy out          | op, pin, edge_fall, edge_rise, time_us,
//          |                             | time_ms, query_code
// result   | done out (one-cycle strobe) | event_valid, event_code, event_type,
//          |                             | event_time_ms, level, lost_events
// config   | cfg_valid in, cfg_ready out | cfg_index, cfg_data
//
// One item per cycle is sustained once clearing ends; each result passes through the two-entry
// command queue and then the execute stage, whose memory reads are registered. The receiver
// cannot stall, so the back end drains the queue every cycle in which it is not clearing.
// After reset, busy stays high while the code level memory is cleared one entry per cycle;
// configuration writes are taken during that time.

module button_debounce_event_queue #(
  parameter int NUM_PINS    = bdeq_pkg::NUM_PINS_DEFAULT,
  parameter int QUEUE_DEPTH = bdeq_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op,
  input  logic [4:0]  pin,
  input  logic        edge_fall,
  input  logic        edge_rise,
  input  logic [31:0] time_us,
  input  logic [31:0] time_ms,
  input  logic [7:0]  query_code,
  output logic        done,
  output logic        event_valid,
  output logic [7:0]  event_code,
  output logic        event_type,
  output logic [31:0] event_time_ms,
  output logic [1:0]  level,
  output logic [31:0] lost_events,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data
);
  import bdeq_pkg::*;

  logic head_valid;
  cmd_t head;
  logic pop;
  logic clearing;

  assign cfg_ready = 1'b1;

  bdeq_front #(
    .NUM_PINS(NUM_PINS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .clearing   (clearing),
    .busy       (busy),
    .op         (op),
    .pin        (pin),
    .edge_fall  (edge_fall),
    .edge_rise  (edge_rise),
    .time_us    (time_us),
    .time_ms    (time_ms),
    .query_code (query_code),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  bdeq_back #(
    .NUM_PINS   (NUM_PINS),
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head          (head),
    .pop           (pop),
    .clearing      (clearing),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .done          (done),
    .event_valid   (event_valid),
    .event_code    (event_code),
    .event_type    (event_type),
    .event_time_ms (event_time_ms),
    .level         (level),
    .lost_events   (lost_events)
  );

endmodule
